[sv/dre_pkg.sv]
`default_nettype none

package dre_pkg;

  // defaults for the top level parameters
  localparam int MAX_RUN_DEF = 63;
  localparam int WIDTH_DEF   = 32;

  // field widths fixed by the interface
  localparam int WORD_W    = 32;
  localparam int PAYLOAD_W = 32;
  localparam int CODE_W    = 7;

  // input function codes
  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // result kinds
  localparam logic KIND_CODE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  // mode register bits
  localparam int MODE_DIFF_BIT = 0;
  localparam int MODE_RLE_BIT  = 1;

  // register indexes (paddr word index)
  localparam logic REG_MODE = 1'b0;

  typedef enum logic [1:0] {
    RUN_NEUTRAL = 2'd0,
    RUN_LITERAL = 2'd1,
    RUN_REPEAT  = 2'd2
  } run_t;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] word;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [PAYLOAD_W-1:0] payload;
    logic                 final_res;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic emitting;
  } status_t;

endpackage

`default_nettype wire

[sv/dre_store.sv]
`default_nettype none

module dre_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/dre_seq.sv]
`default_nettype none

module dre_seq #(
  parameter int WIDTH   = 32,
  parameter int MAX_RUN = 63
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [1:0]                 mode,
  input  wire dre_pkg::in_item_t          item,
  input  wire logic                       item_valid,
  output      logic                       item_ready,
  output      dre_pkg::out_item_t         result,
  output      logic                       result_valid,
  input  wire logic                       result_ready,
  output      logic                       mem_we,
  output      logic [$clog2(MAX_RUN)-1:0] mem_waddr,
  output      logic [WIDTH-1:0]           mem_wdata,
  output      logic                       mem_re,
  output      logic [$clog2(MAX_RUN)-1:0] mem_raddr,
  input  wire logic [WIDTH-1:0]           mem_rdata,
  output      dre_pkg::status_t           status
);

  import dre_pkg::*;

  localparam int AW = $clog2(MAX_RUN);
  localparam int CW = $clog2(MAX_RUN + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_RAWP  = 7'b0000100,
    S_CODE  = 7'b0001000,
    S_RWORD = 7'b0010000,
    S_LREAD = 7'b0100000,
    S_LPUT  = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic             func_q, func_q_next;
  logic [WIDTH-1:0] prev, prev_next;
  logic [WIDTH-1:0] v, v_next;
  run_t             run, run_next;
  logic [CW-1:0]    lit_cnt, lit_cnt_next;
  logic [CW-1:0]    rep_cnt, rep_cnt_next;
  logic [WIDTH-1:0] rep_word, rep_word_next;
  logic             em_rep, em_rep_next;
  logic [CW-1:0]    em_cnt, em_cnt_next;
  logic [WIDTH-1:0] em_word, em_word_next;
  logic [CW-1:0]    em_idx, em_idx_next;
  logic             wb_pend, wb_pend_next;
  logic             load;
  out_item_t        out_next;

  logic             slot_free;
  logic [CW-1:0]    lit_last;
  logic [CW-1:0]    em_last;
  logic [WIDTH-1:0] w_in;
  logic             rep_hit;
  logic             last_hit;

  assign slot_free  = !result_valid || result_ready;
  assign lit_last   = lit_cnt - CW'(1);
  assign em_last    = em_cnt - CW'(1);
  assign w_in       = WIDTH'(item.word);
  assign rep_hit    = (v == rep_word) && (rep_cnt < CW'(MAX_RUN));
  assign last_hit   = (mem_rdata == v);
  assign item_ready = (state == S_IDLE);

  assign status.busy     = (state != S_IDLE);
  assign status.emitting = (state == S_RAWP) || (state == S_CODE) || (state == S_RWORD) ||
                           (state == S_LREAD) || (state == S_LPUT);

  always_comb begin
    state_next    = state;
    func_q_next   = func_q;
    prev_next     = prev;
    v_next        = v;
    run_next      = run;
    lit_cnt_next  = lit_cnt;
    rep_cnt_next  = rep_cnt;
    rep_word_next = rep_word;
    em_rep_next   = em_rep;
    em_cnt_next   = em_cnt;
    em_word_next  = em_word;
    em_idx_next   = em_idx;
    wb_pend_next  = wb_pend;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = v;
    mem_re        = 1'b0;
    mem_raddr     = lit_last[AW-1:0];
    load          = 1'b0;
    out_next      = '0;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          // fetch the last stored literal word for the compare
          mem_re      = 1'b1;
          func_q_next = item.func;
          v_next      = mode[MODE_DIFF_BIT] ? (w_in - prev) : w_in;
          prev_next   = (item.func == FUNC_FLUSH) ? '0 : w_in;
          state_next  = S_LOOK;
        end
      end

      S_LOOK: begin
        state_next = S_IDLE;
        if (func_q == FUNC_FLUSH) begin
          run_next     = RUN_NEUTRAL;
          lit_cnt_next = '0;
          rep_cnt_next = '0;
          if (run == RUN_REPEAT) begin
            em_rep_next  = 1'b1;
            em_cnt_next  = rep_cnt;
            em_word_next = rep_word;
            state_next   = S_CODE;
          end else if (lit_cnt != '0) begin
            em_rep_next = 1'b0;
            em_cnt_next = lit_cnt;
            state_next  = S_CODE;
          end
        end else if (!mode[MODE_RLE_BIT]) begin
          state_next = S_RAWP;
        end else begin
          unique case (run)
            RUN_REPEAT: begin
              if (rep_hit) begin
                rep_cnt_next = rep_cnt + CW'(1);
              end else begin
                em_rep_next  = 1'b1;
                em_cnt_next  = rep_cnt;
                em_word_next = rep_word;
                state_next   = S_CODE;
                run_next     = RUN_NEUTRAL;
                rep_cnt_next = '0;
                mem_we       = 1'b1;
                mem_waddr    = '0;
                lit_cnt_next = CW'(1);
              end
            end
            RUN_LITERAL: begin
              if (last_hit) begin
                // last literal word moves into a new repeated run
                em_rep_next   = 1'b0;
                em_cnt_next   = lit_last;
                state_next    = S_CODE;
                run_next      = RUN_REPEAT;
                lit_cnt_next  = '0;
                rep_word_next = v;
                rep_cnt_next  = CW'(2);
              end else if (lit_cnt >= CW'(MAX_RUN)) begin
                // entry 0 is rewritten once the run has been read out
                em_rep_next  = 1'b0;
                em_cnt_next  = lit_cnt;
                wb_pend_next = 1'b1;
                state_next   = S_CODE;
                run_next     = RUN_NEUTRAL;
                lit_cnt_next = CW'(1);
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = lit_cnt[AW-1:0];
                lit_cnt_next = lit_cnt + CW'(1);
              end
            end
            default: begin
              if (lit_cnt == '0) begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                lit_cnt_next = CW'(1);
              end else if (last_hit) begin
                run_next      = RUN_REPEAT;
                lit_cnt_next  = '0;
                rep_word_next = v;
                rep_cnt_next  = CW'(2);
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = AW'(1);
                lit_cnt_next = CW'(2);
                run_next     = RUN_LITERAL;
              end
            end
          endcase
        end
      end

      S_RAWP: begin
        if (slot_free) begin
          load               = 1'b1;
          out_next.kind      = KIND_WORD;
          out_next.payload   = PAYLOAD_W'(v);
          out_next.final_res = 1'b1;
          state_next         = S_IDLE;
        end
      end

      S_CODE: begin
        if (slot_free) begin
          load               = 1'b1;
          out_next.kind      = KIND_CODE;
          out_next.payload   = PAYLOAD_W'({em_rep, CODE_W'(em_cnt)});
          out_next.final_res = 1'b0;
          em_idx_next        = '0;
          state_next         = em_rep ? S_RWORD : S_LREAD;
        end
      end

      S_RWORD: begin
        if (slot_free) begin
          load               = 1'b1;
          out_next.kind      = KIND_WORD;
          out_next.payload   = PAYLOAD_W'(em_word);
          out_next.final_res = 1'b1;
          state_next         = S_IDLE;
        end
      end

      S_LREAD: begin
        mem_re     = 1'b1;
        mem_raddr  = em_idx[AW-1:0];
        state_next = S_LPUT;
      end

      S_LPUT: begin
        if (slot_free) begin
          load               = 1'b1;
          out_next.kind      = KIND_WORD;
          out_next.payload   = PAYLOAD_W'(mem_rdata);
          out_next.final_res = (em_idx == em_last);
          if (em_idx == em_last) begin
            state_next = S_IDLE;
            if (wb_pend) begin
              mem_we       = 1'b1;
              mem_waddr    = '0;
              wb_pend_next = 1'b0;
            end
          end else begin
            em_idx_next = em_idx + CW'(1);
            state_next  = S_LREAD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev         <= '0;
      run          <= RUN_NEUTRAL;
      lit_cnt      <= '0;
      rep_cnt      <= '0;
      rep_word     <= '0;
      wb_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      prev     <= prev_next;
      run      <= run_next;
      lit_cnt  <= lit_cnt_next;
      rep_cnt  <= rep_cnt_next;
      rep_word <= rep_word_next;
      wb_pend  <= wb_pend_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_q  <= func_q_next;
    v       <= v_next;
    em_rep  <= em_rep_next;
    em_cnt  <= em_cnt_next;
    em_word <= em_word_next;
    em_idx  <= em_idx_next;
    if (load) begin
      result <= out_next;
    end
  end

endmodule

`default_nettype wire

[sv/delta_rle_word_encoder.sv]
// Delta / run-length word encoder. An item is accepted while the last pending
// literal word is fetched from the literal store; the next cycle compares and
// writes back. Without run-length coding, a raw or differenced word then loads
// the output register. A run emission adds the code byte, then the repeated
// word, or for each literal word a store read followed by an output register
// load. Emission stalls while the output register is full and the receiver
// holds off its result. The next item is accepted once the last result of the
// current one sits in the output register. The literal store needs no clearing
// after reset.
// Write the mode register only while the block is idle.
`default_nettype none

module delta_rle_word_encoder #(
  parameter int MAX_RUN = dre_pkg::MAX_RUN_DEF,
  parameter int WIDTH   = dre_pkg::WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input items
  input  wire dre_pkg::in_item_t  item,
  input  wire logic               item_valid,
  output      logic               item_ready,
  // result items
  output      dre_pkg::out_item_t result,
  output      logic               result_valid,
  input  wire logic               result_ready,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  import dre_pkg::*;

  localparam int AW = $clog2(MAX_RUN);

  logic [1:0]       mode;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WIDTH-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [WIDTH-1:0] mem_rdata;
  status_t          status;

  // register port: zero wait states, one register at word index zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? 32'(mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      mode <= pwdata[1:0];
    end
  end

  // sequencer: run-state tracking, compare, write back and result emission
  dre_seq #(
    .WIDTH   (WIDTH),
    .MAX_RUN (MAX_RUN)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .status       (status)
  );

  // literal run store, one read and one write port, registered read
  dre_store #(
    .WIDTH (WIDTH),
    .DEPTH (MAX_RUN)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // one item at a time: the input is not ready in the cycle after an item is accepted
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input accepted while previous item still in work");

  // no input is taken while results are being produced
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    status.emitting |-> !item_ready && status.busy)
    else $error("input ready during result emission");

  // a non-final result leaves the sequencer still busy with its item
  a_not_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.final_res |-> status.busy)
    else $error("item ended without a final result");

endmodule

`default_nettype wire

[test/delta_rle_word_encoder_tb.sv]
`default_nettype none

module delta_rle_word_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dre_pkg::*;

  localparam int MAX_RUN = MAX_RUN_DEF;
  // settle time covers the flush of a full literal run, plus margin
  localparam int SETTLE_CYCLES = 2 * MAX_RUN + 40;
  // cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // long receiver hold-off for the back-pressure test
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP = 40;

  localparam logic [1:0] MODE_RAW      = 2'd0;
  localparam logic [1:0] MODE_DIFF     = 2'd1;
  localparam logic [1:0] MODE_RLE      = 2'd2;
  localparam logic [1:0] MODE_RLE_DIFF = 2'd3;
  localparam logic [2:0] MODE_ADDR     = {REG_MODE, 2'b00};

  // idle / stall percentages for each random phase
  localparam int SEND_IDLE[4] = '{0, 53, 0, 33};
  localparam int RECV_STALL[4] = '{0, 0, 53, 33};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  in_item_t    item = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  out_item_t   result;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  delta_rle_word_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // encoder shadow: run-length state, previous word and mode, kept in step
  // with every item and register write the block accepts
  // ---------------------------------------------------------------------------
  logic [31:0] lit_words [MAX_RUN];
  int unsigned lit_cnt = 0;
  int unsigned rep_cnt = 0;
  logic [31:0] rep_word = '0;
  logic [31:0] last_word = '0;
  run_t        run_st = RUN_NEUTRAL;
  logic [1:0]  mode_shadow = MODE_RAW;

  out_item_t item_out[$];        // results of the item being encoded
  out_item_t predicted_stream[$]; // results still owed by the block
  int        mismatches = 0;

  // knobs shared by the stimulus and the receiver
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic [1:0]  gen_mode = MODE_RAW;
  logic [31:0] gen_last = '0;

  function automatic void put_result(input logic kind, input logic [31:0] pl);
    out_item_t r;
    r.kind = kind;
    r.payload = pl;
    r.final_res = 1'b0;
    item_out = {item_out, r};
  endfunction

  function automatic void emit_literal(input int unsigned cnt);
    int unsigned n;
    n = (cnt > MAX_RUN) ? MAX_RUN : cnt;
    put_result(KIND_CODE, {25'b0, n[6:0]});
    for (int i = 0; i < n; i++) put_result(KIND_WORD, lit_words[i]);
  endfunction

  function automatic void emit_repeat();
    put_result(KIND_CODE, {24'b0, 1'b1, rep_cnt[6:0]});
    put_result(KIND_WORD, rep_word);
  endfunction

  function automatic void start_repeat(input logic [31:0] v);
    run_st = RUN_REPEAT;
    lit_cnt = 0;
    rep_word = v;
    rep_cnt = 2;
  endfunction

  function automatic void rle_step(input logic [31:0] v);
    logic [31:0] tail;
    case (run_st)
      RUN_REPEAT: begin
        if (v == rep_word && rep_cnt < MAX_RUN) begin
          rep_cnt++;
        end else begin
          // run broken or full: the new word waits alone
          emit_repeat();
          run_st = RUN_NEUTRAL;
          rep_cnt = 0;
          lit_words[0] = v;
          lit_cnt = 1;
        end
      end
      RUN_LITERAL: begin
        tail = lit_words[lit_cnt - 1];
        if (v == tail) begin
          // tail word leaves the literal run and opens a repeat of two
          emit_literal(lit_cnt - 1);
          start_repeat(v);
        end else if (lit_cnt >= MAX_RUN) begin
          emit_literal(lit_cnt);
          run_st = RUN_NEUTRAL;
          lit_words[0] = v;
          lit_cnt = 1;
        end else begin
          lit_words[lit_cnt] = v;
          lit_cnt++;
        end
      end
      default: begin
        if (lit_cnt == 0) begin
          lit_words[0] = v;
          lit_cnt = 1;
        end else if (lit_words[0] == v) begin
          start_repeat(v);
        end else begin
          lit_words[1] = v;
          lit_cnt = 2;
          run_st = RUN_LITERAL;
        end
      end
    endcase
  endfunction

  function automatic void encode_item(input in_item_t it);
    logic [31:0] v;
    if (it.func == FUNC_FLUSH) begin
      // flush empties pending run state in every mode
      if (run_st == RUN_REPEAT) emit_repeat();
      else if (lit_cnt > 0) emit_literal(lit_cnt);
      run_st = RUN_NEUTRAL;
      lit_cnt = 0;
      rep_cnt = 0;
      last_word = '0;
    end else begin
      v = mode_shadow[MODE_DIFF_BIT] ? it.word - last_word : it.word;
      last_word = it.word;
      if (mode_shadow[MODE_RLE_BIT]) rle_step(v);
      else put_result(KIND_WORD, v);
    end
    if (item_out.size() > 0) item_out[item_out.size() - 1].final_res = 1'b1;
    predicted_stream = {predicted_stream, item_out};
    item_out.delete();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: register writes and accepted items feed the shadow, accepted
  // results are checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      lit_cnt = 0;
      rep_cnt = 0;
      rep_word = '0;
      last_word = '0;
      run_st = RUN_NEUTRAL;
      mode_shadow = MODE_RAW;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
        mode_shadow = pwdata[1:0];
      if (item_valid && item_ready) encode_item(item);
      if (result_valid && result_ready) begin
        if (predicted_stream.size() == 0) begin
          report_mismatch("unexpected result", result.payload, '0);
        end else begin
          want = predicted_stream.pop_front();
          if (result.kind !== want.kind)
            report_mismatch("kind", 32'(result.kind), 32'(want.kind));
          if (result.payload !== want.payload)
            report_mismatch("payload", result.payload, want.payload);
          if (result.final_res !== want.final_res)
            report_mismatch("final_res", 32'(result.final_res), 32'(want.final_res));
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang guard: cycles without any handshake or register access
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("no progress for %0d cycles", HANG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic func, input logic [31:0] word);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    it.func = func;
    it.word = word;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic accum_word(input logic [31:0] w);
    send_item(FUNC_ACCUM, w);
    gen_last = w;
  endtask

  // send the word whose encoded value is v in the current mode
  task automatic push_value(input logic [31:0] v);
    accum_word(gen_mode[MODE_DIFF_BIT] ? gen_last + v : v);
  endtask

  task automatic end_plane();
    send_item(FUNC_FLUSH, $urandom);
    gen_last = '0;
  endtask

  // wait until every owed result is out and the block has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    while (predicted_stream.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= {30'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gen_mode = m;
  endtask

  // mostly short runs, now and then one around the cap
  function automatic int run_len();
    if ($urandom_range(7) == 0) return $urandom_range(MAX_RUN + 2, MAX_RUN - 2);
    return $urandom_range(6, 1);
  endfunction

  // well-formed runs with random content, plus noise and plane ends
  task automatic send_runs(input int n_items);
    int          sent;
    int          len;
    logic [31:0] v;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          end_plane();
          sent++;
        end
        1, 2, 3: begin
          v = $urandom;
          len = run_len();
          repeat (len) push_value(v);
          sent += len;
        end
        4, 5, 6: begin
          len = run_len();
          repeat (len) push_value($urandom);
          sent += len;
        end
        default: begin
          // tiny alphabet, so repeats pop up at random places
          len = $urandom_range(8, 1);
          repeat (len) push_value($urandom_range(3));
          sent += len;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // mode left at its reset value: raw words, flushes with nothing pending
  task automatic test_raw_after_reset();
    accum_word(32'h0000_0000);
    accum_word(32'hFFFF_FFFF);
    accum_word(32'h8000_0000);
    accum_word(32'h7FFF_FFFF);
    end_plane();
    end_plane();
  endtask

  // differenced words, wrap-around, previous word cleared by flush
  task automatic test_differenced();
    set_mode(MODE_DIFF);
    accum_word(32'd5);
    accum_word(32'd3);
    accum_word(32'h0000_0000);
    accum_word(32'hFFFF_FFFF);
    end_plane();
    accum_word(32'd9);
    end_plane();
  endtask

  // repeat, break into literal, literal tail turning into a repeat,
  // single pending word flushed as a literal of one
  task automatic test_run_length();
    set_mode(MODE_RLE);
    repeat (3) accum_word(32'hFFFF_FFFF);
    accum_word(32'h0000_0000);
    accum_word(32'h8000_0000);
    accum_word(32'h1234_5678);
    accum_word(32'h1234_5678);
    end_plane();
    accum_word(32'h0F0F_0F0F);
    end_plane();
  endtask

  // pending literal kept across mode changes until flushed
  task automatic test_mode_switch();
    set_mode(MODE_RLE);
    accum_word(32'h0000_00A1);
    accum_word(32'h0000_00B2);
    set_mode(MODE_RAW);
    accum_word(32'h0000_0100);
    set_mode(MODE_RLE_DIFF);
    accum_word(32'd10);
    accum_word(32'd20);
    accum_word(32'd30);
    end_plane();
  endtask

  // repeat and literal runs at and just past the cap
  task automatic test_run_caps();
    logic [31:0] v;
    set_mode(MODE_RLE);
    v = $urandom;
    repeat (MAX_RUN + 1) push_value(v);
    repeat (MAX_RUN + 1) push_value($urandom);
    end_plane();
    v = $urandom;
    repeat (MAX_RUN) push_value(v);
    end_plane();
    set_mode(MODE_RLE_DIFF);
    v = $urandom;
    repeat (MAX_RUN + 2) push_value(v);
    end_plane();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_RAW);
    hold_left <= HOLD_CYCLES;
    repeat (40) push_value($urandom);
    end_plane();
    settle();
  endtask

  task automatic test_random_planes();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      // segments end unflushed at times, so state crosses mode writes
      repeat (2) begin
        set_mode(2'($urandom_range(3)));
        send_runs(20);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_RLE_DIFF);
    send_runs(20);
    end_plane();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_raw_after_reset();
    test_differenced();
    test_run_length();
    test_mode_switch();
    test_run_caps();
    test_backpressure();
    test_random_planes();

    settle();
    if (predicted_stream.size() != 0)
      report_mismatch("results never delivered", predicted_stream.size(), '0);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/dre_pkg.sv
sv/dre_store.sv
sv/dre_seq.sv
sv/delta_rle_word_encoder.sv
test/delta_rle_word_encoder_tb.sv
